// File: rtl/ucs_pkg.sv
// Package: shared types and constants for the UDP checksum engine.
package ucs_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [15:0] SUM_MASK   = 16'hffff;
  localparam logic [15:0] PROTO_UDP  = 16'd17;
  localparam logic [15:0] OFF_LEN_HI = 16'd4;
  localparam logic [15:0] OFF_LEN_LO = 16'd5;
  localparam logic [15:0] OFF_CK_HI  = 16'd6;
  localparam logic [15:0] OFF_CK_LO  = 16'd7;

  typedef enum logic {
    OP_ADDR    = 1'b0,
    OP_SEGMENT = 1'b1
  } op_t;

  // One classified input transfer: words to add and the end-of-packet mark.
  typedef struct packed {
    logic [15:0] data_word;
    logic [15:0] extra_word;
    logic        last;
  } q_entry_t;

endpackage

// File: rtl/ucs_if.sv
// Channel interfaces: byte input and checksum result.
interface ucs_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] byte_value;
  logic       last;

  modport source (output valid, output op, output byte_value, output last, input ready);
  modport sink (input valid, input op, input byte_value, input last, output ready);
endinterface

interface ucs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] checksum;

  modport source (output valid, output checksum, input ready);
  modport sink (input valid, input checksum, output ready);
endinterface

// File: rtl/ucs_front.sv
// Front end: accepts bytes, pairs them into words and classifies segment offsets.
module ucs_front
  import ucs_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  ucs_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          q_push,
  output q_entry_t      q_entry
);

  logic [15:0] offset_r, offset_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        parity_r, parity_nxt;
  logic        addr_seen_r, addr_seen_nxt;

  logic        is_seg;
  logic        take;
  logic        pair_done;
  logic        addr_after;
  logic [15:0] len_word;
  logic [15:0] proto_word;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    is_seg     = (in_ch.op == OP_SEGMENT);
    take       = !is_seg || ((offset_r != OFF_CK_HI) && (offset_r != OFF_CK_LO));
    pair_done  = take && parity_r;
    addr_after = addr_seen_r || !is_seg;

    held_nxt   = held_r;
    parity_nxt = parity_r;
    if (take) begin
      held_nxt   = parity_r ? 8'h00 : in_ch.byte_value;
      parity_nxt = !parity_r;
    end

    len_word = 16'h0000;
    if (is_seg && addr_seen_r) begin
      if (offset_r == OFF_LEN_HI) begin
        len_word = {in_ch.byte_value, 8'h00};
      end else if (offset_r == OFF_LEN_LO) begin
        len_word = {8'h00, in_ch.byte_value};
      end
    end
    proto_word = (in_ch.last && addr_after) ? PROTO_UDP : 16'h0000;

    // length byte plus protocol word never carries out of 16 bits
    q_entry.last       = in_ch.last;
    q_entry.extra_word = len_word + proto_word;
    if (pair_done) begin
      q_entry.data_word = {held_r, in_ch.byte_value};
    end else if (in_ch.last && parity_nxt) begin
      q_entry.data_word = {held_nxt, 8'h00};
    end else begin
      q_entry.data_word = 16'h0000;
    end

    offset_nxt = offset_r;
    if (is_seg && (offset_r != SUM_MASK)) begin
      offset_nxt = offset_r + 16'd1;
    end
    addr_seen_nxt = addr_after;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= '0;
      held_r      <= '0;
      parity_r    <= 1'b0;
      addr_seen_r <= 1'b0;
    end else if (q_push) begin
      if (in_ch.last) begin
        offset_r    <= '0;
        held_r      <= '0;
        parity_r    <= 1'b0;
        addr_seen_r <= 1'b0;
      end else begin
        offset_r    <= offset_nxt;
        held_r      <= held_nxt;
        parity_r    <= parity_nxt;
        addr_seen_r <= addr_seen_nxt;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && in_ch.last) |=> (offset_r == 16'd0 && !parity_r && !addr_seen_r))
    else $error("front state not cleared after packet end");

  a_held_zero_even: assert property (@(posedge clk) disable iff (!rst_n)
    !parity_r |-> (held_r == 8'h00))
    else $error("held byte nonzero with no byte pending");

  a_len_needs_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !addr_seen_r && !in_ch.last) |-> (q_entry.extra_word == 16'h0000))
    else $error("length word added without address bytes");

endmodule

// File: rtl/ucs_queue.sv
// Short FIFO between the front end and the accumulator.
module ucs_queue
  import ucs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  output logic     pop_valid,
  output q_entry_t pop_entry,
  input  logic     pop
);

  q_entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !pop_valid))
    else $error("queue underflow");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

// File: rtl/ucs_back.sv
// Back end: one's-complement accumulator and registered checksum output.
module ucs_back
  import ucs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  q_entry_t  q_entry,
  output logic      q_pop,
  ucs_out_if.source out_ch
);

  logic [15:0] acc_r;
  logic        out_valid_r;
  logic [15:0] checksum_r;

  logic        can_emit;
  logic [17:0] sum3;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] res;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.checksum = checksum_r;

  always_comb begin
    can_emit = !out_valid_r || out_ch.ready;
    q_pop    = q_valid && (!q_entry.last || can_emit);
    sum3     = {2'b00, acc_r} + {2'b00, q_entry.data_word} + {2'b00, q_entry.extra_word};
    fold1    = {1'b0, sum3[15:0]} + {15'd0, sum3[17:16]};
    fold2    = fold1[15:0] + {15'd0, fold1[16]};
    res      = ~fold2;
    if (res == 16'h0000) begin
      res = SUM_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        acc_r <= q_entry.last ? 16'h0000 : fold2;
      end
      if (q_pop && q_entry.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_entry.last) begin
      checksum_r <= res;
    end
  end

  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_entry.last) |=> (acc_r == 16'h0000))
    else $error("accumulator not cleared after packet end");

  a_no_result_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !(q_pop && q_entry.last))
    else $error("result overwritten while stalled");

  a_result_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (checksum_r != 16'h0000))
    else $error("zero checksum emitted");

endmodule

// File: rtl/udp_checksum_engine.sv
// Top level: UDP checksum engine, front end, queue and accumulator.
//
//  channel   dir   handshake        payload
//  in_ch     in    valid / ready    op, byte_value, last
//  out_ch    out   valid / ready    checksum
//
//  One byte per cycle while the queue is not full; after the last byte's transfer
//  the checksum passes through the queue slot, then the output register.
//  The accumulator folds up to three words per cycle in one end-around-carry add.
//  A two-entry queue decouples the front end from the accumulator; a stalled
//  output only blocks the queue at the next packet end.
//  rst_n is synchronous, active low, and clears all packet state.
module udp_checksum_engine
  import ucs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ucs_in_if.sink    in_ch,
  ucs_out_if.source out_ch
);

  logic     q_full;
  logic     q_push;
  q_entry_t push_entry;
  logic     q_valid;
  q_entry_t pop_entry;
  logic     q_pop;

  ucs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (push_entry)
  );

  ucs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_entry  (pop_entry),
    .pop        (q_pop)
  );

  ucs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_entry (pop_entry),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
